@@ hdl/aes128_block_encrypt_macros.svh @@
// ----------------------------------------------------------------------------
// AES-128 block encryptor assertion macros
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// Property must hold at every edge out of reset.
`define AES_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// Constants, S-box table and byte-level round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int unsigned ROUND_COUNT = 10;
    localparam int unsigned KEY_WORDS   = 44;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 64;

    typedef logic [127:0] t_block;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_HIGH = 1'b0;
    localparam t_cfg_idx CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUND_COUNT] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Block byte i sits at bits 127-8i..120-8i; byte r+4c is row r, column c.
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hdl/aes_key_expand.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Registered schedule: one round key per cycle after a key write, held until
// the next write. Done flag rises once all eleven round keys are settled.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_expand (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire aes_pkg::t_block i_key,
    input  wire                  i_key_wr,
    output aes_pkg::t_block      o_rkey [aes_pkg::ROUND_COUNT+1],
    output logic                 o_ready
);
    import aes_pkg::*;

    localparam int unsigned CNT_W = $clog2(ROUND_COUNT + 1);

    t_block           r_rk [ROUND_COUNT+1];
    logic [CNT_W-1:0] r_cnt;
    logic             r_ready;

    // Each round key derived from the previous; one step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ready <= 1'b0;
        end else if (i_key_wr) begin
            r_cnt   <= '0;
            r_ready <= 1'b0;
        end else if (!r_ready) begin
            if (r_cnt == CNT_W'(ROUND_COUNT)) begin
                r_ready <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk[0] <= i_key;
    end

    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_rk
        logic [31:0] w_t;
        logic [31:0] w0, w1, w2, w3;
        // RotWord: rotate the last word left by one byte.
        assign w_t = sub_word({r_rk[g-1][23:0], r_rk[g-1][31:24]})
                     ^ {RCON[g-1], 24'h0};
        assign w0  = r_rk[g-1][127:96] ^ w_t;
        assign w1  = r_rk[g-1][95:64]  ^ w0;
        assign w2  = r_rk[g-1][63:32]  ^ w1;
        assign w3  = r_rk[g-1][31:0]   ^ w2;
        always_ff @(posedge i_clk) begin
            r_rk[g] <= {w0, w1, w2, w3};
        end
    end

    assign o_rkey  = r_rk;
    assign o_ready = r_ready;

endmodule

`default_nettype wire

@@ hdl/aes128_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encryptor
// Fully unrolled, one-round-per-stage AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
// Encrypts one 128-bit block per beat under the key in registers 0 (key bytes
// 0..7) and 1 (key bytes 8..15). A new beat is accepted every cycle while the
// pipe advances and the round keys are settled; each beat passes one stage for
// the initial AddRoundKey and ten round stages (the last round stage drives the
// output directly), eleven cascaded stages in all. The whole pipe advances
// together and freezes when the output beat is not taken. After a key write
// the round-key schedule rebuilds one round key per cycle; s_axis_tready
// stays low until all round keys are settled.
`default_nettype none

`include "aes128_block_encrypt_macros.svh"

module aes128_block_encrypt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // tdata: plain_high[63:0], plain_low[127:64]
    input  wire  [127:0]                 s_axis_tdata,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: cipher_high[63:0], cipher_low[127:64]
    output logic [127:0]                 m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire                          i_cfg_we,
    input  wire  aes_pkg::t_cfg_idx      i_cfg_idx,
    input  wire  [aes_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import aes_pkg::*;

    logic [63:0] r_key_hi, r_key_lo;
    t_block      w_rkey [ROUND_COUNT+1];
    logic        w_keys_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_hi <= i_cfg_data;
                CFG_KEY_LOW:  r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Key write after reset restarts the schedule too.
    logic r_kwr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kwr <= 1'b1;
        else          r_kwr <= i_cfg_we;
    end

    aes_key_expand u_kexp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    ({r_key_hi, r_key_lo}),
        .i_key_wr (r_kwr || i_cfg_we),
        .o_rkey   (w_rkey),
        .o_ready  (w_keys_ok)
    );

    // Stage 0: initial AddRoundKey; stages 1..ROUND_COUNT: one round each.
    t_block r_st [ROUND_COUNT+1];
    logic   r_vl [ROUND_COUNT+1];
    logic   w_adv;

    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv && w_keys_ok;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ w_rkey[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vl[0] <= 1'b0;
        else if (w_adv) r_vl[0] <= s_axis_tvalid && w_keys_ok;
    end

    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_rnd
        t_block w_ss;
        t_block w_nx;
        assign w_ss = sub_shift(r_st[g-1]);
        assign w_nx = ((g == ROUND_COUNT) ? w_ss : mix_columns(w_ss)) ^ w_rkey[g];
        always_ff @(posedge i_clk) begin
            if (w_adv) r_st[g] <= w_nx;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vl[g] <= 1'b0;
            else if (w_adv) r_vl[g] <= r_vl[g-1];
        end
    end

    // Output register is the last round stage.
    assign m_axis_tdata  = {r_st[ROUND_COUNT][63:0], r_st[ROUND_COUNT][127:64]};
    assign m_axis_tvalid = r_vl[ROUND_COUNT];

    `AES_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output beat changed under stall")
    `AES_ASSERT_ALWAYS(a_nokey, i_clk, i_rst_n, !(s_axis_tready && !w_keys_ok),
        "input accepted before round keys settled")
    `AES_ASSERT_NEXT(a_cfgblk, i_clk, i_rst_n, i_cfg_we, !s_axis_tready,
        "input ready right after key write")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// AES-128 block encryptor testbench
// Drives plaintext beats under several keys and checks every ciphertext beat
// against a behavioral AES-128 predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import aes_pkg::*;

    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 1650;

    typedef struct packed {
        logic [63:0] plain_low;
        logic [63:0] plain_high;
    } t_plain_beat;

    typedef struct packed {
        logic [63:0] cipher_low;
        logic [63:0] cipher_high;
    } t_cipher_beat;

    // Directed row: plaintext and, where known by heart, the ciphertext.
    typedef struct {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        bit          known;
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_directed_row;

    logic         i_clk;
    logic         i_rst_n;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_we;
    t_cfg_idx     i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    aes128_block_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),   // plain_high[63:0], plain_low[127:64]
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // cipher_high[63:0], cipher_low[127:64]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor's own copy of the key registers.
    logic [63:0] key_hi_model;
    logic [63:0] key_lo_model;

    t_cipher_beat cipher_queue[$];
    int           mismatches;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_cycles;

    // ------------------------------------------------------------------
    // GF(2^8) helpers and the cipher itself, byte array form
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = gf_double(a);
            b = b >> 1;
        end
        return p;
    endfunction

    // S-box from the field inverse and affine map, not from a table.
    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv, base, y;
        int e;
        inv = 8'h01;
        base = x;
        e = 254;
        while (e != 0) begin
            if (e & 1) inv = gf_mul(inv, base);
            base = gf_mul(base, base);
            e = e >> 1;
        end
        if (x == 8'h00) inv = 8'h00;
        y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return y;
    endfunction

    function automatic t_cipher_beat encrypt_block(input logic [63:0] key_hi,
                                                   input logic [63:0] key_lo,
                                                   input logic [63:0] pt_hi,
                                                   input logic [63:0] pt_lo);
        logic [31:0] sched [KEY_WORDS];
        logic [31:0] t;
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  rc, a0, a1, a2, a3;
        t_cipher_beat res;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < KEY_WORDS; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]),
                     sub_byte(t[7:0])} ^ {rc, 24'h0};
                rc = gf_double(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            st[i]   = pt_hi[63-8*i -: 8];
            st[i+8] = pt_lo[63-8*i -: 8];
        end
        for (int rnd = 0; rnd <= ROUND_COUNT; rnd++) begin
            if (rnd > 0) begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        tmp[r+4*c] = sub_byte(st[r+4*((c+r)%4)]);
                st = tmp;
                if (rnd < ROUND_COUNT) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        st[4*c]   = gf_double(a0) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                        st[4*c+1] = a0 ^ gf_double(a1) ^ gf_mul(a2, 8'h03) ^ a3;
                        st[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_mul(a3, 8'h03);
                        st[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_double(a3);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[r+4*c] ^= sched[4*rnd+c][31-8*r -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            res.cipher_high[63-8*i -: 8] = st[i];
            res.cipher_low[63-8*i -: 8]  = st[i+8];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = 64'h1 << $urandom_range(0, 63);
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aes128_block_encrypt verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, optional long hold-off, checking
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_cipher_beat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (cipher_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected ciphertext beat %h", m_axis_tdata);
            end else begin
                want = cipher_queue.pop_front();
                if (got.cipher_high !== want.cipher_high
                        || got.cipher_low !== want.cipher_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cipher mismatch: exp %h_%h got %h_%h",
                                 want.cipher_high, want.cipher_low,
                                 got.cipher_high, got.cipher_low);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // tvalid stays high into the next beat; callers drop it when done.
    task automatic send_block(input logic [63:0] pt_hi, input logic [63:0] pt_lo);
        t_plain_beat b;
        b.plain_high = pt_hi;
        b.plain_low  = pt_lo;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        cipher_queue.push_back(encrypt_block(key_hi_model, key_lo_model, pt_hi, pt_lo));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Key writes only with the pipe drained and after a settle pause.
    task automatic write_key(input t_cfg_idx idx, input logic [63:0] value);
        s_axis_tvalid <= 1'b0;
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_KEY_HIGH) key_hi_model = value;
        else                     key_lo_model = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    t_directed_row directed [] = '{
        // all-zero reset key, zero block
        '{64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
        '{64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
        '{64'h0, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] ph, pl;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_KEY_HIGH;
        i_cfg_data = '0;
        key_hi_model = '0;
        key_lo_model = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (LATENCY + 2) @(posedge i_clk);

        // Directed rows under the reset key.
        foreach (directed[i]) begin
            send_block(directed[i].plain_high, directed[i].plain_low);
            if (directed[i].known) begin
                cipher_queue[cipher_queue.size()-1].cipher_high = directed[i].cipher_high;
                cipher_queue[cipher_queue.size()-1].cipher_low  = directed[i].cipher_low;
            end
        end

        // FIPS-197 appendix C.1 vector.
        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        cipher_queue[cipher_queue.size()-1].cipher_high = 64'h69c4e0d86a7b0430;
        cipher_queue[cipher_queue.size()-1].cipher_low  = 64'hd8cdb78070b4c55a;

        // Key extremes.
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW,  '1);
        send_block('0, '0);
        send_block('1, '1);
        write_key(CFG_KEY_HIGH, '0);
        send_block(64'hdeadbeefcafef00d, '1);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off_cycles = 60;
        for (int i = 0; i < 20; i++) send_block(rand64(), rand64());

        // Random part in three idling phases, key changed every so often.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 0)                   begin send_idle_pct = 8;  recv_idle_pct = 88; end
            if (n == RANDOM_BEATS/3)      begin send_idle_pct = 88; recv_idle_pct = 8;  end
            if (n == 2*RANDOM_BEATS/3)    begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            if (n % 200 == 0) begin
                write_key(CFG_KEY_HIGH, rand64());
                write_key(CFG_KEY_LOW,  rand64());
            end
            ph = rand64();
            pl = rand64();
            send_block(ph, pl);
        end
        s_axis_tvalid <= 1'b0;

        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("aes128_block_encrypt verification clean");
        end else begin
            $display("aes128_block_encrypt verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ aes128_block_encrypt.f @@
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_key_expand.sv
hdl/aes128_block_encrypt.sv
dv/tb_top.sv
